/* rtl/core/frc_pkg.sv */
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the flow range classifier: stream layouts,
// configuration register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package frc_pkg;

	localparam int RULE_SLOTS_DEF = 64;
	localparam int MAX_SLOTS      = 64;

	// field widths
	localparam int SLOT_W   = 6;
	localparam int LABEL_W  = 32;
	localparam int BOUND_W  = 32;
	localparam int PORT_W   = 16;
	localparam int FLOW_W   = 32;
	localparam int LEN_W    = 16;
	localparam int LBITS_W  = 19;

	// slave tdata layout, lowest bit up
	localparam int S_SLOT_LSB  = 0;
	localparam int S_LABEL_LSB = S_SLOT_LSB + SLOT_W;
	localparam int S_LOW_LSB   = S_LABEL_LSB + LABEL_W;
	localparam int S_HIGH_LSB  = S_LOW_LSB + BOUND_W;
	localparam int S_PORT_LSB  = S_HIGH_LSB + BOUND_W;
	localparam int S_FLOW_LSB  = S_PORT_LSB + PORT_W;
	localparam int S_LEN_LSB   = S_FLOW_LSB + FLOW_W;
	localparam int S_ENCAP_BIT = S_LEN_LSB + LEN_W;
	localparam int S_DATA_W    = ((S_ENCAP_BIT + 1 + 7) / 8) * 8;

	// slave tuser layout
	localparam int S_OPCODE_BIT = 0;
	localparam int S_ISFLOW_BIT = 1;
	localparam int S_USER_W     = 2;

	// master tdata layout, lowest bit up
	localparam int M_SLOT_LSB  = 0;
	localparam int M_LABEL_LSB = M_SLOT_LSB + SLOT_W;
	localparam int M_LBITS_LSB = M_LABEL_LSB + LABEL_W;
	localparam int M_ENCAP_BIT = M_LBITS_LSB + LBITS_W;
	localparam int M_PAD_W     = ((M_ENCAP_BIT + 1 + 7) / 8) * 8 - (M_ENCAP_BIT + 1);
	localparam int M_DATA_W    = M_ENCAP_BIT + 1 + M_PAD_W;
	localparam int M_USER_W    = 1;

	// opcodes
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOWID_EN   = 1'd1;

	typedef struct packed {
		logic load_entry;  // write the accepted rule into its slot
		logic cap_pkt;     // hold the accepted packet fields
		logic compute;     // compare all lanes, load the pending mask
		logic pick;        // take the lowest pending slot, read its label
		logic send;        // move the picked result into the output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;    // output register empty or being drained
		logic pick_last;   // picked result is the final one of the packet
	} dp_status_t;

endpackage

/* rtl/core/frc_ctrl.sv */
// ----------------------------------------------------------------------------
// frc_ctrl
// Sequencer of the flow range classifier: accepts words, then steps the
// datapath through lane compare, result pick and result send.
// ----------------------------------------------------------------------------
module frc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               opcode,
	output logic               s_tready,
	output frc_pkg::ctrl_cmd_t cmd,
	input  frc_pkg::dp_status_t st
);
	import frc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PICK,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign s_tready = ready_q;
	assign accept   = s_tvalid & ready_q;

	always_comb begin
		cmd            = '0;
		cmd.load_entry = accept & (opcode == OP_LOAD);
		cmd.cap_pkt    = accept & (opcode == OP_CLASSIFY);
		cmd.compute    = (state_q == ST_MATCH);
		cmd.pick       = (state_q == ST_PICK);
		cmd.send       = (state_q == ST_SEND) & st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.cap_pkt) begin
						state_q <= ST_MATCH;
						ready_q <= 1'b0;
					end
				end
				ST_MATCH: state_q <= ST_PICK;
				ST_PICK:  state_q <= ST_SEND;
				ST_SEND: begin
					// hold until the output register can take the result
					if (st.out_free) begin
						if (st.pick_last) begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= ST_PICK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/core/frc_datapath.sv */
// ----------------------------------------------------------------------------
// frc_datapath
// Rule lanes with range comparators, label memory, pending match mask,
// lowest-slot picker, configuration registers and output register.
// ----------------------------------------------------------------------------
module frc_datapath #(
	parameter int RULE_SLOTS = frc_pkg::RULE_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  frc_pkg::ctrl_cmd_t               cmd,
	output frc_pkg::dp_status_t              st,
	input  logic [frc_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic [frc_pkg::S_USER_W-1:0]     s_tuser,
	input  logic                             cfg_valid,
	input  logic [frc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [frc_pkg::M_DATA_W-1:0]     m_tdata,
	output logic [frc_pkg::M_USER_W-1:0]     m_tuser,
	output logic                             m_tlast
);
	import frc_pkg::*;

	localparam int IDX_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int GROUPS = (RULE_SLOTS + 7) / 8;
	localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int PW     = GW + 3;

	// input word fields
	logic [SLOT_W-1:0]  in_slot;
	logic [LABEL_W-1:0] in_label;
	logic [BOUND_W-1:0] in_low, in_high;
	logic               in_isflow;
	logic               slot_ok;
	logic [IDX_W-1:0]   wr_idx;

	assign in_slot   = s_tdata[S_SLOT_LSB +: SLOT_W];
	assign in_label  = s_tdata[S_LABEL_LSB +: LABEL_W];
	assign in_low    = s_tdata[S_LOW_LSB +: BOUND_W];
	assign in_high   = s_tdata[S_HIGH_LSB +: BOUND_W];
	assign in_isflow = s_tuser[S_ISFLOW_BIT];
	assign slot_ok   = {1'b0, in_slot} < (SLOT_W + 1)'(RULE_SLOTS);
	assign wr_idx    = in_slot[IDX_W-1:0];

	// configuration
	logic [CFG_DATA_W-1:0] entry_count_q;
	logic                  fid_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			fid_en_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENTRY_COUNT: entry_count_q <= cfg_data;
				REG_FLOWID_EN:   fid_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// rule lanes
	logic [PORT_W-1:0]  port_lo_q [RULE_SLOTS];
	logic [PORT_W-1:0]  port_hi_q [RULE_SLOTS];
	logic [BOUND_W-1:0] flow_lo_q [RULE_SLOTS];
	logic [BOUND_W-1:0] flow_hi_q [RULE_SLOTS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < RULE_SLOTS; i++) begin
			if (cmd.load_entry && slot_ok && wr_idx == IDX_W'(i)) begin
				if (in_isflow) begin
					// port range 0..0 never hits a nonzero port
					port_lo_q[i] <= '0;
					port_hi_q[i] <= '0;
					flow_lo_q[i] <= in_low;
					flow_hi_q[i] <= in_high;
				end else begin
					port_lo_q[i] <= in_low[PORT_W-1:0];
					port_hi_q[i] <= in_high[PORT_W-1:0];
					flow_lo_q[i] <= '0;
					flow_hi_q[i] <= '0;
				end
			end
		end
	end

	// held packet
	logic [PORT_W-1:0] port_q;
	logic [FLOW_W-1:0] flow_q;
	logic [LEN_W-1:0]  len_q;
	logic              encap_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_pkt) begin
			port_q  <= s_tdata[S_PORT_LSB +: PORT_W];
			flow_q  <= s_tdata[S_FLOW_LSB +: FLOW_W];
			len_q   <= s_tdata[S_LEN_LSB +: LEN_W];
			encap_q <= s_tdata[S_ENCAP_BIT];
		end
	end

	// lane compare
	logic [RULE_SLOTS-1:0] active;
	logic [RULE_SLOTS-1:0] hit;

	always_comb begin
		for (int i = 0; i < RULE_SLOTS; i++) begin
			active[i] = (CFG_DATA_W)'(i) < entry_count_q;
			hit[i]    = active[i] & (
				((port_q != '0) && (port_lo_q[i] <= port_q) && (port_hi_q[i] >= port_q)) ||
				(fid_en_q && (flow_q != '0) && (flow_lo_q[i] <= flow_q) &&
				 (flow_hi_q[i] >= flow_q)));
		end
	end

	// lowest pending slot: first nonzero byte, then first bit in it
	logic [RULE_SLOTS-1:0] pending_q;
	logic                  first_q;
	logic [GROUPS*8-1:0]   pend_pad;
	logic [GROUPS-1:0]     grp_any;
	logic [GW-1:0]         grp_sel;
	logic [7:0]            grp_bits;
	logic [2:0]            bit_sel;
	logic [PW-1:0]         pick_full;
	logic [IDX_W-1:0]      pick_idx;
	logic [RULE_SLOTS-1:0] pend_next;

	always_comb begin
		pend_pad = (GROUPS * 8)'(pending_q);
		grp_sel  = '0;
		for (int g = 0; g < GROUPS; g++) begin
			grp_any[g] = |pend_pad[g*8 +: 8];
		end
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (grp_any[g]) grp_sel = GW'(g);
		end
		grp_bits = pend_pad[grp_sel*8 +: 8];
		bit_sel  = '0;
		for (int b = 7; b >= 0; b--) begin
			if (grp_bits[b]) bit_sel = 3'(b);
		end
		pick_full = {grp_sel, bit_sel};
		pick_idx  = pick_full[IDX_W-1:0];
		for (int i = 0; i < RULE_SLOTS; i++) begin
			pend_next[i] = pending_q[i] & (pick_idx != IDX_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			first_q   <= 1'b0;
		end else if (cmd.compute) begin
			pending_q <= hit;
			first_q   <= 1'b1;
		end else if (cmd.pick) begin
			pending_q <= pend_next;
			first_q   <= 1'b0;
		end
	end

	// label memory
	logic [LABEL_W-1:0] label_mem [RULE_SLOTS];
	logic [LABEL_W-1:0] label_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load_entry && slot_ok) begin
			label_mem[wr_idx] <= in_label;
		end
		if (cmd.pick) begin
			label_rd_q <= label_mem[pick_idx];
		end
	end

	// picked result
	logic             matched_q;
	logic [IDX_W-1:0] slot_q;
	logic             enc_q;
	logic             last_q;

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			matched_q <= (pending_q != '0);
			slot_q    <= (pending_q != '0) ? pick_idx : '0;
			enc_q     <= first_q ? encap_q : 1'b1;
			last_q    <= (pend_next == '0);
		end
	end

	// output register
	logic                m_valid_q;
	logic [SLOT_W-1:0]   m_slot_q;
	logic [LABEL_W-1:0]  m_label_q;
	logic [LBITS_W-1:0]  m_lbits_q;
	logic                m_encap_q;
	logic                m_matched_q;
	logic                m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.send) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.send) begin
			m_slot_q    <= SLOT_W'(slot_q);
			m_label_q   <= matched_q ? label_rd_q : '0;
			m_lbits_q   <= {len_q, 3'b000};
			m_encap_q   <= enc_q;
			m_matched_q <= matched_q;
			m_last_q    <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_matched_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_encap_q, m_lbits_q, m_label_q, m_slot_q};

	assign st.out_free  = ~m_valid_q | m_tready;
	assign st.pick_last = last_q;

	// checks
	a_send_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send |-> st.out_free)
		else $error("result sent while output register is occupied");

	a_compute_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compute |=> first_q)
		else $error("first-result flag not set after lane compare");

	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compute |=> ((pending_q & ~$past(active)) == '0))
		else $error("pending match outside active slots");

	a_pick_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick |-> (first_q || (pending_q != '0)))
		else $error("pick with nothing left to report");

endmodule

/* rtl/core/flow_range_classifier.sv */
// ----------------------------------------------------------------------------
// flow_range_classifier
// Range-match packet classifier over a table of port and flow-number rules.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: a word with tuser opcode 0 loads a rule into its slot in the
//   cycle it is accepted (slots at or above RULE_SLOTS are dropped); opcode 1
//   classifies a packet. Master stream: one word per matching slot in slot
//   order, or one unmatched word; tlast marks the final word of a packet.
//   Config channel: cfg_index 0 = entry_count, 1 = flowid_match_enable; it is
//   always ready, and the user must write it only while no packet is in
//   flight; the block itself does not enforce this.
//   Sequencing: after acceptance a packet passes lane compare, where all
//   lanes compare together, then for each result a label memory read and an
//   output register load; the next word is taken only once the final result
//   is loaded. Loads do not hold off the next word.
//   Reset clears the output, sets entry_count to 0 and flow-number matching
//   on; rule contents are not cleared and must be loaded before use.
//   A stalled receiver holds the output register; the sequencer waits, and
//   the final result may still be waiting while the next word is accepted.
// ----------------------------------------------------------------------------
module flow_range_classifier #(
	parameter int RULE_SLOTS = frc_pkg::RULE_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_slot, entry_label, entry_low, entry_high, pkt_port,
	// pkt_flow_number, pkt_length_bytes, pkt_encapsulated, zero pad
	input  logic [frc_pkg::S_DATA_W-1:0]    s_tdata,
	// opcode, entry_is_flowid
	input  logic [frc_pkg::S_USER_W-1:0]    s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// match_slot, flow_label, length_bits, encap_mark, zero pad
	output logic [frc_pkg::M_DATA_W-1:0]    m_tdata,
	// matched
	output logic [frc_pkg::M_USER_W-1:0]    m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [frc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import frc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	frc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser[S_OPCODE_BIT]),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	frc_datapath #(
		.RULE_SLOTS (RULE_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* tb/flow_range_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_range_classifier_tb
// Loads rule tables, classifies packets and checks every result word against
// an in-bench prediction of the slot-ordered match list. Config is changed
// between phases while the block is drained; both streams idle at random.
// ----------------------------------------------------------------------------
module flow_range_classifier_tb;
	import frc_pkg::*;

	localparam int SLOTS       = RULE_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_PCT    = 18;

	typedef struct {
		logic                op;
		logic [SLOT_W-1:0]   slot;
		logic [LABEL_W-1:0]  label;
		logic                is_flow;
		logic [BOUND_W-1:0]  lo;
		logic [BOUND_W-1:0]  hi;
		logic [PORT_W-1:0]   port;
		logic [FLOW_W-1:0]   flow;
		logic [LEN_W-1:0]    len;
		logic                encap;
	} frc_word_t;

	typedef struct {
		logic                matched;
		logic [SLOT_W-1:0]   slot;
		logic [LABEL_W-1:0]  label;
		logic [LBITS_W-1:0]  lbits;
		logic                encap;
		logic                last;
	} frc_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata   = '0;
	logic [S_USER_W-1:0]    s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_DATA_W-1:0]    m_tdata;
	logic [M_USER_W-1:0]    m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	frc_word_t   stim_words[$];
	frc_result_t predicted_records[$];
	frc_word_t   live_word;
	int          offered    = 0;
	int          taken      = 0;
	bit          calm       = 1'b0;
	int          mismatches = 0;
	int          words_seen = 0;
	int          cycles     = 0;
	int          hold_left  = 0;
	bit          hold_done  = 1'b0;

	// predicted block state
	logic [PORT_W-1:0]   tbl_plo[SLOTS];
	logic [PORT_W-1:0]   tbl_phi[SLOTS];
	logic [FLOW_W-1:0]   tbl_flo[SLOTS];
	logic [FLOW_W-1:0]   tbl_fhi[SLOTS];
	logic [LABEL_W-1:0]  tbl_label[SLOTS];
	logic [CFG_DATA_W-1:0] active_limit = '0;
	logic                flow_en = 1'b1;

	// rule shapes as generated, used to aim packets at rules
	bit                  gen_flow[SLOTS];
	logic [31:0]         gen_lo[SLOTS];
	logic [31:0]         gen_hi[SLOTS];

	flow_range_classifier #(.RULE_SLOTS(SLOTS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [S_DATA_W-1:0] pack_data(frc_word_t w);
		logic [S_DATA_W-1:0] d;
		d = '0;
		d[S_SLOT_LSB +: SLOT_W]   = w.slot;
		d[S_LABEL_LSB +: LABEL_W] = w.label;
		d[S_LOW_LSB +: BOUND_W]   = w.lo;
		d[S_HIGH_LSB +: BOUND_W]  = w.hi;
		d[S_PORT_LSB +: PORT_W]   = w.port;
		d[S_FLOW_LSB +: FLOW_W]   = w.flow;
		d[S_LEN_LSB +: LEN_W]     = w.len;
		d[S_ENCAP_BIT]            = w.encap;
		return d;
	endfunction

	function automatic logic [S_USER_W-1:0] pack_user(frc_word_t w);
		logic [S_USER_W-1:0] u;
		u = '0;
		u[S_OPCODE_BIT] = w.op;
		u[S_ISFLOW_BIT] = w.is_flow;
		return u;
	endfunction

	// update the rule table or build the slot-ordered match list of a packet
	function automatic void classify_word(frc_word_t w);
		logic [SLOTS-1:0] hits;
		frc_result_t      r;
		int               n;
		bit               hit;
		bit               first;
		if (w.op == OP_LOAD) begin
			if (w.slot < SLOTS) begin
				tbl_label[w.slot] = w.label;
				if (w.is_flow) begin
					tbl_flo[w.slot] = w.lo;
					tbl_fhi[w.slot] = w.hi;
					tbl_plo[w.slot] = '0;
					tbl_phi[w.slot] = '0;
				end else begin
					tbl_plo[w.slot] = w.lo[PORT_W-1:0];
					tbl_phi[w.slot] = w.hi[PORT_W-1:0];
					tbl_flo[w.slot] = '0;
					tbl_fhi[w.slot] = '0;
				end
			end
			return;
		end
		n = (active_limit > SLOTS) ? SLOTS : active_limit;
		hits = '0;
		for (int s = 0; s < n; s++) begin
			hit = w.port != 0 && tbl_plo[s] <= w.port && tbl_phi[s] >= w.port;
			if (flow_en && w.flow != 0 && tbl_flo[s] <= w.flow && tbl_fhi[s] >= w.flow)
				hit = 1'b1;
			hits[s] = hit;
		end
		r.lbits = {w.len, 3'b000};
		if (hits == '0) begin
			r.matched = 1'b0;
			r.slot    = '0;
			r.label   = '0;
			r.encap   = w.encap;
			r.last    = 1'b1;
			predicted_records.push_back(r);
			return;
		end
		first = 1'b1;
		for (int s = 0; s < SLOTS; s++) begin
			if (hits[s]) begin
				hits[s]   = 1'b0;
				r.matched = 1'b1;
				r.slot    = SLOT_W'(s);
				r.label   = tbl_label[s];
				r.encap   = first ? w.encap : 1'b1;
				r.last    = (hits == '0);
				first     = 1'b0;
				predicted_records.push_back(r);
			end
		end
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// driver: offer the next pending word, hold it until taken
	always @(negedge clk) begin
		if (arst_n && offered == taken) begin
			if (stim_words.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				live_word = stim_words.pop_front();
				offered++;
				s_tvalid <= 1'b1;
				s_tdata  <= pack_data(live_word);
				s_tuser  <= pack_user(live_word);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// input and config acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				classify_word(live_word);
				taken++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENTRY_COUNT)
					active_limit = cfg_data;
				else if (cfg_index == REG_FLOWID_EN)
					flow_en = cfg_data[0];
			end
		end
	end

	// receiver ready, with one long hold-off once traffic is flowing
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && words_seen >= 40) begin
			hold_done = 1'b1;
			hold_left = 300;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		frc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (predicted_records.size() == 0) begin
				report("word with nothing predicted", m_tdata, 0);
			end else begin
				want = predicted_records.pop_front();
				if (m_tuser[0] !== want.matched)
					report("matched", m_tuser[0], want.matched);
				if (m_tdata[M_SLOT_LSB +: SLOT_W] !== want.slot)
					report("match_slot", m_tdata[M_SLOT_LSB +: SLOT_W], want.slot);
				if (m_tdata[M_LABEL_LSB +: LABEL_W] !== want.label)
					report("flow_label", m_tdata[M_LABEL_LSB +: LABEL_W], want.label);
				if (m_tdata[M_LBITS_LSB +: LBITS_W] !== want.lbits)
					report("length_bits", m_tdata[M_LBITS_LSB +: LBITS_W], want.lbits);
				if (m_tdata[M_ENCAP_BIT] !== want.encap)
					report("encap_mark", m_tdata[M_ENCAP_BIT], want.encap);
				if (m_tlast !== want.last)
					report("last", m_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("flow_range_classifier: mismatch");
			$finish;
		end
	end

	// every field random, so unused fields toggle too
	function automatic frc_word_t noise_word();
		frc_word_t w;
		w.op      = 1'($urandom_range(0, 1));
		w.slot    = SLOT_W'($urandom);
		w.label   = $urandom;
		w.is_flow = 1'($urandom_range(0, 1));
		w.lo      = $urandom;
		w.hi      = $urandom;
		w.port    = PORT_W'($urandom);
		w.flow    = $urandom;
		w.len     = LEN_W'($urandom);
		w.encap   = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic frc_word_t rule_load(int slot, bit is_flow, logic [31:0] lo,
			logic [31:0] hi);
		frc_word_t w;
		w = noise_word();
		w.op      = OP_LOAD;
		w.slot    = SLOT_W'(slot);
		w.is_flow = is_flow;
		w.lo      = lo;
		w.hi      = hi;
		gen_flow[slot] = is_flow;
		gen_lo[slot]   = is_flow ? lo : {16'h0, lo[15:0]};
		gen_hi[slot]   = is_flow ? hi : {16'h0, hi[15:0]};
		return w;
	endfunction

	function automatic frc_word_t packet(logic [15:0] port, logic [31:0] flow,
			logic [15:0] len, logic encap);
		frc_word_t w;
		w = noise_word();
		w.op    = OP_CLASSIFY;
		w.port  = port;
		w.flow  = flow;
		w.len   = len;
		w.encap = encap;
		return w;
	endfunction

	// mostly narrow ranges, a few wide or inverted ones
	function automatic frc_word_t random_rule(int slot);
		bit              is_flow;
		int              roll;
		int              base;
		int              top;
		logic [31:0]     lo;
		logic [31:0]     hi;
		logic [31:0]     tmp;
		longint unsigned sum;
		is_flow = 1'($urandom_range(0, 1));
		roll    = $urandom_range(0, 99);
		if (!is_flow) begin
			base = $urandom_range(0, 65535);
			top  = (roll >= 8 && roll < 11) ? 65535 : base + $urandom_range(0, 300);
			if (top > 65535)
				top = 65535;
			lo = {16'($urandom), 16'(base)};
			hi = {16'($urandom), 16'(top)};
		end else begin
			lo  = (roll >= 8 && roll < 11) ? $urandom_range(0, 255) : $urandom;
			sum = (roll >= 8 && roll < 11) ? 64'hffffffff : lo + $urandom_range(0, 1000);
			hi  = (sum > 64'hffffffff) ? 32'hffffffff : sum[31:0];
		end
		if (roll < 8) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		return rule_load(slot, is_flow, lo, hi);
	endfunction

	// aim most packets into a live rule's range, the rest are noise
	function automatic frc_word_t random_packet(int limit);
		int              n;
		int              s;
		int              roll;
		logic [15:0]     port;
		logic [31:0]     flow;
		longint unsigned span;
		n    = (limit > SLOTS) ? SLOTS : limit;
		roll = $urandom_range(0, 99);
		port = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0;
		flow = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom);
		if (roll < 75 && n > 0) begin
			s = $urandom_range(0, n - 1);
			if (gen_lo[s] <= gen_hi[s]) begin
				if (gen_flow[s]) begin
					span = longint'(gen_hi[s]) - longint'(gen_lo[s]) + 1;
					flow = 32'(gen_lo[s] + ($urandom % span));
					if ($urandom_range(0, 3) != 0)
						port = 16'h0;
				end else begin
					port = 16'($urandom_range(gen_lo[s], gen_hi[s]));
					if ($urandom_range(0, 2) != 0)
						flow = 32'h0;
				end
			end
		end
		return packet(port, flow, 16'($urandom), 1'($urandom_range(0, 1)));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every word is taken and every result has come back
	task automatic drain();
		while (stim_words.size() != 0 || offered != taken || predicted_records.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_phase(int count, int limit);
		repeat (count) begin
			if ($urandom_range(0, 99) < 15)
				stim_words.push_back(random_rule($urandom_range(0, SLOTS - 1)));
			else
				stim_words.push_back(random_packet(limit));
		end
	endtask

	initial begin
		int phase_count[6];
		int phase_flow[6];
		int phase_items[6];
		phase_count = '{64, 127, 16, 1, 0, 40};
		phase_flow  = '{1, 1, 0, 1, 1, 1};
		phase_items = '{70, 45, 45, 25, 15, 55};

		repeat (3) @(posedge clk);
		#2 arst_n = 1'b1;

		// no active slots after reset: always unmatched
		stim_words.push_back(packet(16'd80, 32'd5, 16'h0000, 1'b0));
		stim_words.push_back(packet(16'hffff, 32'hffffffff, 16'hffff, 1'b1));

		// port rule with junk in the upper bound bits, flow rule, inverted
		// ranges of both kinds, full ranges and single-value ranges at the top
		stim_words.push_back(rule_load(0, 1'b0, 32'h1234_0050, 32'habcd_0060));
		stim_words.push_back(rule_load(1, 1'b1, 32'd100, 32'd200));
		stim_words.push_back(rule_load(2, 1'b0, 32'd500, 32'd400));
		stim_words.push_back(rule_load(3, 1'b1, 32'h9000_0000, 32'h8000_0000));
		stim_words.push_back(rule_load(4, 1'b0, 32'h0, 32'hffffffff));
		stim_words.push_back(rule_load(5, 1'b1, 32'h0, 32'hffffffff));
		stim_words.push_back(rule_load(6, 1'b0, 32'h0000_ffff, 32'hffff_ffff));
		stim_words.push_back(rule_load(7, 1'b1, 32'hffffffff, 32'hffffffff));
		stim_words.push_back(random_rule(SLOTS - 1));
		drain();
		write_reg(REG_ENTRY_COUNT, 7'd8);

		stim_words.push_back(packet(16'd85, 32'd0, 16'h0000, 1'b1));
		stim_words.push_back(packet(16'd0, 32'd150, 16'hffff, 1'b0));
		stim_words.push_back(packet(16'd0, 32'd0, 16'd1234, 1'b1));
		stim_words.push_back(packet(16'hffff, 32'hffffffff, 16'hffff, 1'b1));
		stim_words.push_back(packet(16'd450, 32'd0, 16'd7, 1'b0));
		stim_words.push_back(packet(16'h1234, 32'd1, 16'd64, 1'b0));
		drain();
		write_reg(REG_FLOWID_EN, 7'd0);
		stim_words.push_back(packet(16'd0, 32'd150, 16'd100, 1'b1));
		stim_words.push_back(packet(16'hffff, 32'hffffffff, 16'd9, 1'b0));
		drain();
		write_reg(REG_FLOWID_EN, 7'd1);

		// fill the whole table before any phase can reach it
		for (int s = 0; s < SLOTS; s++)
			stim_words.push_back(random_rule(s));
		drain();

		for (int i = 0; i < 6; i++) begin
			write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(phase_count[i]));
			write_reg(REG_FLOWID_EN, CFG_DATA_W'(phase_flow[i]));
			calm = (i == 2);
			run_phase(phase_items[i], phase_count[i]);
			drain();
		end
		calm = 1'b0;

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("flow_range_classifier: match");
		else
			$display("flow_range_classifier: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/frc_pkg.sv
rtl/core/frc_ctrl.sv
rtl/core/frc_datapath.sv
rtl/core/flow_range_classifier.sv
tb/flow_range_classifier_tb.sv
